// File: design/gc3_pkg.sv
// Shared types and constants for the 3x3 horizontal-gradient filter.
// No dependencies; imported by gradient_conv3x3_clamp_unit.
`default_nettype none

package gc3_pkg;

   // Configuration register indexes, taken from paddr[2]
   localparam logic REG_WIDTH_IDX  = 1'b0;
   localparam logic REG_HEIGHT_IDX = 1'b1;

   localparam int unsigned CFG_DIM_W = 11;
   localparam int unsigned APB_ADDR_W = 3;
   localparam int unsigned APB_DATA_W = 32;

   // Smallest frame dimension the datapath supports
   localparam logic [CFG_DIM_W-1:0] DIM_MIN = 11'd4;
   localparam logic [CFG_DIM_W-1:0] DIM_RESET = 11'd1024;

   // Input item codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int unsigned PIX_W = 8;
   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // Kernel weight of the centre row (outer rows weigh one)
   localparam logic signed [11:0] KERNEL_MID = 12'sd3;

   // Result queue depth: one beat in flight plus a skid entry plus the head
   localparam int unsigned FIFO_DEPTH = 3;

   typedef struct packed {
      logic emit;
      logic border;
      logic last;
   } stage_ctrl_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             last;
   } result_type;

endpackage

`default_nettype wire

// File: design/gradient_conv3x3_clamp_unit.sv
// An accepted beat issues its line-store read and loads the stage-1 registers; from stage 1
// its result is written into the result queue, raising rsp_valid, and can then leave.
// Throughput: one beat per cycle; req_ready drops only while queued plus stage-1 results fill
// the three-entry queue. Outputs trail by one row plus one pixel; width+1 drain beats flush.
// Reset (synchronous, active high) sets width and height to 1024, clears the position,
// the window and the result queue; line-store contents are undefined until written.
`default_nettype none

module gradient_conv3x3_clamp_unit #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // pixel input channel
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_op,
   input  wire logic [gc3_pkg::PIX_W-1:0]          req_pixel_in,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [gc3_pkg::PIX_W-1:0]               rsp_pixel_out,
   output logic                                    rsp_frame_last,
   // configuration port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [gc3_pkg::APB_ADDR_W-1:0]     paddr,
   input  wire logic [gc3_pkg::APB_DATA_W-1:0]     pwdata,
   output logic [gc3_pkg::APB_DATA_W-1:0]          prdata,
   output logic                                    pready
);
   import gc3_pkg::*;

   // Column index into the line stores, column arithmetic width (holds width itself),
   // and row width (the row counter runs to height+1 while draining).
   localparam int unsigned ColW  = $clog2(MAX_WIDTH);
   localparam int unsigned DimW  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RowW  = $clog2(MAX_HEIGHT + 2);

   // ---------------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------------
   logic [CFG_DIM_W-1:0] width_ff, width_in;
   logic [CFG_DIM_W-1:0] height_ff, height_in;
   logic                 csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_WIDTH_IDX:  width_in  = pwdata[CFG_DIM_W-1:0];
            REG_HEIGHT_IDX: height_in = pwdata[CFG_DIM_W-1:0];
            default:        width_in  = width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_WIDTH_IDX:  prdata = APB_DATA_W'(width_ff);
         REG_HEIGHT_IDX: prdata = APB_DATA_W'(height_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Effective dimensions: clamp to the supported range
   logic [DimW-1:0] w_eff;
   logic [RowW-1:0] h_eff;

   always_comb begin
      if (width_ff < DIM_MIN)             w_eff = DimW'(DIM_MIN);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = DimW'(MAX_WIDTH);
      else                                w_eff = DimW'(width_ff);
      if (height_ff < DIM_MIN)              h_eff = RowW'(DIM_MIN);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = RowW'(MAX_HEIGHT);
      else                                  h_eff = RowW'(height_ff);
   end

   // ---------------------------------------------------------------------------------
   // Stage 0: accept, advance the raster position, issue the line-store read
   // ---------------------------------------------------------------------------------
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;

   logic            in_fire;
   logic            input_phase;
   logic            take;          // beat that changes state (drain ticks mid-frame do not)
   logic [DimW-1:0] col_ext, col_next, out_c;
   logic [RowW-1:0] out_r;
   logic            col_wrap;
   stage_ctrl_type  ctrl0;

   assign in_fire     = req_valid && req_ready;
   assign input_phase = row_ff < h_eff;
   assign take        = in_fire && !(input_phase && (req_op == OP_DRAIN));

   assign col_ext  = DimW'(col_ff);
   assign col_next = col_ext + DimW'(1);
   assign col_wrap = col_next >= w_eff;

   always_comb begin
      // Output position: the window centre sits one row and one pixel behind the input
      if (col_ff == '0) begin
         out_r = row_ff - RowW'(2);
         out_c = w_eff - DimW'(1);
      end else begin
         out_r = row_ff - RowW'(1);
         out_c = col_ext - DimW'(1);
      end
      ctrl0.emit   = (row_ff >= RowW'(2)) || ((row_ff == RowW'(1)) && (col_ff != '0));
      ctrl0.border = (out_c == '0) || (out_c >= w_eff - DimW'(2)) ||
                     (out_r == '0) || (out_r >= h_eff - RowW'(2));
      ctrl0.last   = ctrl0.emit && (out_r == h_eff - RowW'(1)) &&
                     (out_c == w_eff - DimW'(1));
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (ctrl0.last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + RowW'(1);
         end else begin
            col_in = col_next[ColW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1 registers: control, column and the new pixel (zero while draining)
   logic            s1_valid_ff;
   stage_ctrl_type  s1_ctrl_ff;
   logic [ColW-1:0] s1_col_ff;
   logic [PIX_W-1:0] s1_px_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_ctrl_ff  <= '0;
      end else begin
         s1_valid_ff <= take;
         s1_ctrl_ff  <= ctrl0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_col_ff <= col_ff;
         s1_px_ff  <= input_phase ? req_pixel_in : '0;
      end
   end

   // ---------------------------------------------------------------------------------
   // Line stores: read at stage 0, written back at stage 1
   // ---------------------------------------------------------------------------------
   logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
   logic [PIX_W-1:0] q_up_ff, q_mid_ff;
   logic [PIX_W-1:0] up_eff, mid_eff;
   logic             fwd_ff;
   logic [PIX_W-1:0] fwd_up_ff, fwd_mid_ff;
   logic             mem_hit;

   // Forward the stage-1 write when the read hits the same column (frame restart)
   assign up_eff  = fwd_ff ? fwd_up_ff  : q_up_ff;
   assign mid_eff = fwd_ff ? fwd_mid_ff : q_mid_ff;
   assign mem_hit = s1_valid_ff && (s1_col_ff == col_ff);

   always_ff @(posedge clock) begin
      if (take) begin
         q_up_ff  <= upper_mem[col_ff];
         q_mid_ff <= middle_mem[col_ff];
      end
      if (s1_valid_ff) begin
         upper_mem[s1_col_ff]  <= mid_eff;
         middle_mem[s1_col_ff] <= s1_px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (take) begin
         fwd_ff <= mem_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         fwd_up_ff  <= mid_eff;
         fwd_mid_ff <= s1_px_ff;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stage 1: shift the window and compute the clamped gradient
   // ---------------------------------------------------------------------------------
   logic [PIX_W-1:0] win_ff [3][3];
   logic [PIX_W-1:0] win_in [3][3];
   logic [PIX_W-1:0] new_col [3];

   assign new_col[0] = up_eff;
   assign new_col[1] = mid_eff;
   assign new_col[2] = s1_px_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            win_in[k][j] = win_ff[k][j];
         end
      end
      if (csr_write) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               win_in[k][j] = '0;
            end
         end
      end else if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k][0] = win_ff[k][1];
            win_in[k][1] = win_ff[k][2];
            win_in[k][2] = new_col[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < 3; j++) begin
            if (reset) win_ff[k][j] <= '0;
            else       win_ff[k][j] <= win_in[k][j];
         end
      end
   end

   // Right column minus left column of the shifted window
   logic signed [11:0] d_up, d_mid, d_low, grad;
   logic [PIX_W-1:0]   grad_clamped;
   result_type         s1_result;

   always_comb begin
      d_up  = $signed({4'b0, up_eff})   - $signed({4'b0, win_ff[0][1]});
      d_mid = $signed({4'b0, mid_eff})  - $signed({4'b0, win_ff[1][1]});
      d_low = $signed({4'b0, s1_px_ff}) - $signed({4'b0, win_ff[2][1]});
      grad  = d_up + (d_mid * KERNEL_MID) + d_low;
      if (grad < 12'sd0)                          grad_clamped = '0;
      else if (grad > $signed({4'b0, PIX_MAX}))   grad_clamped = PIX_MAX;
      else                                        grad_clamped = grad[PIX_W-1:0];
      // Border pixels pass the window centre through
      s1_result.pixel = s1_ctrl_ff.border ? win_ff[1][2] : grad_clamped;
      s1_result.last  = s1_ctrl_ff.last;
   end

   // ---------------------------------------------------------------------------------
   // Result queue: decouples the pipeline from rsp_ready
   // ---------------------------------------------------------------------------------
   result_type fifo_ff [FIFO_DEPTH];
   logic [1:0] wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign push      = s1_valid_ff && s1_ctrl_ff.emit;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = cnt_ff != 2'd0;
   assign rsp_pixel_out  = fifo_ff[rd_ptr_ff].pixel;
   assign rsp_frame_last = fifo_ff[rd_ptr_ff].last;

   // Hold off input once queued plus in-flight results would fill the queue
   assign req_ready = ({1'b0, cnt_ff} + {2'b0, push}) < 3'(FIFO_DEPTH);

   always_ff @(posedge clock) begin
      if (push) fifo_ff[wr_ptr_ff] <= s1_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_ptr_ff + 2'd1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_ptr_ff + 2'd1;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

`ifndef SYNTHESIS
   // Queue occupancy never passes its depth
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cnt_ff} <= 3'(FIFO_DEPTH))
      else $error("result queue overflow");

   // Row counter never runs past the drain row that ends a frame
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= h_eff + RowW'(1))
      else $error("row counter past frame end");

   // The flagged output of a frame leaves the position at the frame start
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_ctrl_ff.last) |-> (col_ff == '0 && row_ff == '0))
      else $error("position not restarted after last pixel");

   // A configuration write restarts the frame
   a_cfg_restart: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (col_ff == '0 && row_ff == '0))
      else $error("configuration write did not restart the frame");
`endif

endmodule

`default_nettype wire
